// File: design/assert_macros.svh
// Assertion macros used by the top-level RTL file of the click classifier
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, checked out of reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: design/bcc_pkg.sv
// Types and constants shared by the click classifier modules
package bcc_pkg;

    localparam int unsigned LIMIT_W = 8;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [LIMIT_W-1:0] LONG_PRESS_RST = 8'd100;
    localparam logic [LIMIT_W-1:0] DOUBLE_GAP_RST = 8'd30;

    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_GAP = 1'd1;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_VERIFY = 3'd1,
        PH_FIRST  = 3'd2,
        PH_GAP    = 3'd3,
        PH_SECOND = 3'd4,
        PH_LONG   = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_SINGLE = 2'd1,
        EV_DOUBLE = 2'd2,
        EV_LONG   = 2'd3
    } t_event;

    // Result of one scan tick, handed to the output stage
    typedef struct packed {
        logic   valid;
        t_event evt;
    } t_evt_beat;

    // Debounce machine status
    typedef struct packed {
        t_phase             phase;
        logic [LIMIT_W-1:0] count;
    } t_fsm_status;

    // Limit registers
    typedef struct packed {
        logic [LIMIT_W-1:0] long_press;
        logic [LIMIT_W-1:0] double_gap;
    } t_limits;

endpackage

// File: design/button_click_classifier.sv
// Top level of the button click classifier
//
// Usage:
//   One slave-side item per key scan tick; bit 0 of s_axis_tdata is the
//   sampled key level (1 = pressed). Every accepted item yields exactly one
//   master-side item whose m_axis_tdata[1:0] is the event: none, single
//   click, double click or long press.
//   The limits (long-press hold ticks, double-click gap ticks) are written
//   through i_cfg_we / i_cfg_idx / i_cfg_data while no item is in flight;
//   a limit of 0 acts like 1.
// Timing:
//   The phase machine updates in the cycle the item is accepted and the
//   event is held in one output register, so the result appears in the cycle
//   after acceptance. One item per cycle is taken while the output register
//   is empty or drained in the same cycle.
// Reset (synchronous, active low):
//   Phase returns to idle, counter to zero, limits to 100 and 30, and the
//   output register empties.
// Stall:
//   While m_axis_tready is low with a result pending, s_axis_tready drops
//   and the pending result is held unchanged.
`include "assert_macros.svh"

module button_click_classifier
    import bcc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // config port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [LIMIT_W-1:0]   i_cfg_data,
    // scan tick stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,  // [0] key_pressed, [7:1] zero
    // event stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [7:0]           m_axis_tdata   // [1:0] click_event, [7:2] zero
);

    t_limits     w_limits;
    t_evt_beat   w_beat;
    t_fsm_status w_status;
    t_event      w_out_evt;
    logic        w_free;
    logic        w_step;

    assign s_axis_tready = w_free;
    assign w_step        = s_axis_tvalid && w_free;

    bcc_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_limits   (w_limits)
    );

    bcc_fsm u_fsm (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (w_step),
        .i_key_pressed (s_axis_tdata[0]),
        .i_limits      (w_limits),
        .o_beat        (w_beat),
        .o_status      (w_status)
    );

    bcc_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_beat   (w_beat),
        .i_tready (m_axis_tready),
        .o_free   (w_free),
        .o_tvalid (m_axis_tvalid),
        .o_evt    (w_out_evt)
    );

    assign m_axis_tdata = {6'd0, w_out_evt};

    // Checks
    `ASSERT_NEXT(a_accept_gives_result, i_clk, i_rst_n, w_step, m_axis_tvalid)
    `ASSERT_IMPLY(a_long_count_clear, i_clk, i_rst_n,
        w_status.phase == PH_LONG, w_status.count == '0)
    `ASSERT_IMPLY(a_second_count_clear, i_clk, i_rst_n,
        w_status.phase == PH_SECOND, w_status.count == '0)
    `ASSERT_NEXT(a_double_from_second, i_clk, i_rst_n,
        w_beat.valid && w_beat.evt == EV_DOUBLE, w_status.phase == PH_IDLE)

endmodule

// File: design/bcc_cfg.sv
// Limit registers of the click classifier, written through the config port
module bcc_cfg
    import bcc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [LIMIT_W-1:0]   i_cfg_data,
    output t_limits              o_limits
);

    t_limits r_limits;
    t_limits n_limits;

    // Decode the register index
    always_comb begin
        n_limits = r_limits;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LONG_PRESS: n_limits.long_press = i_cfg_data;
                CFG_DOUBLE_GAP: n_limits.double_gap = i_cfg_data;
                default:        n_limits = r_limits;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limits.long_press <= LONG_PRESS_RST;
            r_limits.double_gap <= DOUBLE_GAP_RST;
        end else begin
            r_limits <= n_limits;
        end
    end

    assign o_limits = r_limits;

endmodule

// File: design/bcc_fsm.sv
// Press classification state machine and tick counter
module bcc_fsm
    import bcc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  logic        i_key_pressed,
    input  t_limits     i_limits,
    output t_evt_beat   o_beat,
    output t_fsm_status o_status
);

    t_phase             r_phase;
    t_phase             n_phase;
    logic [LIMIT_W-1:0] r_count;
    logic [LIMIT_W-1:0] n_count;
    logic [LIMIT_W-1:0] w_count_inc;
    t_event             w_evt;

    // Counter bumps first, then compares
    assign w_count_inc = r_count + LIMIT_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_count <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_count <= n_count;
        end
    end

    // Next phase, counter and event for this tick
    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        w_evt   = EV_NONE;
        case (r_phase)
            PH_IDLE: begin
                if (i_key_pressed) n_phase = PH_VERIFY;
            end
            PH_VERIFY: begin
                n_phase = i_key_pressed ? PH_FIRST : PH_IDLE;
            end
            PH_FIRST: begin
                if (!i_key_pressed) begin
                    n_phase = PH_GAP;
                    n_count = '0;
                end else if (w_count_inc >= i_limits.long_press) begin
                    n_phase = PH_LONG;
                    n_count = '0;
                    w_evt   = EV_LONG;
                end else begin
                    n_count = w_count_inc;
                end
            end
            PH_GAP: begin
                if (i_key_pressed) begin
                    n_phase = PH_SECOND;
                    n_count = '0;
                end else if (w_count_inc >= i_limits.double_gap) begin
                    n_phase = PH_IDLE;
                    n_count = '0;
                    w_evt   = EV_SINGLE;
                end else begin
                    n_count = w_count_inc;
                end
            end
            PH_SECOND: begin
                if (!i_key_pressed) begin
                    n_phase = PH_IDLE;
                    w_evt   = EV_DOUBLE;
                end
            end
            PH_LONG: begin
                if (!i_key_pressed) n_phase = PH_IDLE;
            end
            default: begin
                // unreachable codes recover to idle
                n_phase = PH_IDLE;
                n_count = '0;
            end
        endcase
    end

    assign o_beat.valid     = i_step;
    assign o_beat.evt       = w_evt;
    assign o_status.phase   = r_phase;
    assign o_status.count   = r_count;

endmodule

// File: design/bcc_out.sv
// Output register stage for click events
module bcc_out
    import bcc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_evt_beat i_beat,
    input  logic      i_tready,
    output logic      o_free,
    output logic      o_tvalid,
    output t_event    o_evt
);

    logic   r_valid;
    t_event r_evt;

    // Stage can take an item when empty or when its item leaves now
    assign o_free = !r_valid || i_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_beat.valid) begin
            r_valid <= 1'b1;
        end else if (i_tready) begin
            r_valid <= 1'b0;
        end
    end

    // Payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_beat.valid) begin
            r_evt <= i_beat.evt;
        end
    end

    assign o_tvalid = r_valid;
    assign o_evt    = r_evt;

endmodule

// File: sim/bcc_checker.sv
// Scoreboard for the click classifier: predicts each tick's event, checks the event stream
module bcc_checker
    import bcc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [LIMIT_W-1:0]   i_cfg_data,
    input  logic                 i_tick_valid,
    input  logic                 i_tick_ready,
    input  logic [7:0]           i_tick_data,   // [0] key_pressed, [7:1] zero
    input  logic                 i_evt_valid,
    input  logic                 i_evt_ready,
    input  logic [7:0]           i_evt_data,    // [1:0] click_event, [7:2] zero
    output int unsigned          o_fail_count,
    output int unsigned          o_pending,
    output int unsigned          o_checked
);

    localparam int unsigned REPORT_MAX = 10;

    // predicted machine state and limits
    t_phase             key_phase  = PH_IDLE;
    logic [LIMIT_W-1:0] press_ticks = '0;
    logic [LIMIT_W-1:0] long_limit = LONG_PRESS_RST;
    logic [LIMIT_W-1:0] gap_limit  = DOUBLE_GAP_RST;

    t_event      expected_events[$];
    int unsigned mismatch_count = 0;
    int unsigned events_checked = 0;

    assign o_fail_count = mismatch_count;
    assign o_pending    = expected_events.size();
    assign o_checked    = events_checked;

    // advance the predicted machine by one tick, return the event it gives
    function automatic t_event classify_tick(input logic key);
        t_event ev;
        ev = EV_NONE;
        case (key_phase)
            PH_IDLE: begin
                if (key) key_phase = PH_VERIFY;
            end
            PH_VERIFY: begin
                key_phase = key ? PH_FIRST : PH_IDLE;
            end
            PH_FIRST: begin
                if (!key) begin
                    key_phase   = PH_GAP;
                    press_ticks = '0;
                end else begin
                    press_ticks = press_ticks + 8'd1;
                    if (press_ticks >= long_limit) begin
                        press_ticks = '0;
                        key_phase   = PH_LONG;
                        ev          = EV_LONG;
                    end
                end
            end
            PH_GAP: begin
                if (key) begin
                    key_phase   = PH_SECOND;
                    press_ticks = '0;
                end else begin
                    press_ticks = press_ticks + 8'd1;
                    if (press_ticks >= gap_limit) begin
                        press_ticks = '0;
                        key_phase   = PH_IDLE;
                        ev          = EV_SINGLE;
                    end
                end
            end
            PH_SECOND: begin
                if (!key) begin
                    key_phase = PH_IDLE;
                    ev        = EV_DOUBLE;
                end
            end
            PH_LONG: begin
                if (!key) key_phase = PH_IDLE;
            end
            default: begin
                key_phase   = PH_IDLE;
                press_ticks = '0;
            end
        endcase
        return ev;
    endfunction

    // watch config, event and tick channels at every rising edge
    always @(posedge i_clk) begin
        t_event exp_ev;
        if (!i_rst_n) begin
            key_phase   = PH_IDLE;
            press_ticks = '0;
            long_limit  = LONG_PRESS_RST;
            gap_limit   = DOUBLE_GAP_RST;
            expected_events.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_LONG_PRESS: long_limit = i_cfg_data;
                    CFG_DOUBLE_GAP: gap_limit  = i_cfg_data;
                    default: ;
                endcase
            end

            // event item: compare with the oldest prediction
            if (i_evt_valid && i_evt_ready) begin
                if (expected_events.size() == 0) begin
                    if (mismatch_count < REPORT_MAX)
                        $display("event with no tick pending: tdata 0x%02h", i_evt_data);
                    mismatch_count++;
                end else begin
                    exp_ev = expected_events.pop_front();
                    if (i_evt_data !== {6'd0, exp_ev}) begin
                        if (mismatch_count < REPORT_MAX)
                            $display("event %0d mismatch: expected %0d, got tdata 0x%02h",
                                     events_checked, exp_ev, i_evt_data);
                        mismatch_count++;
                    end
                    events_checked++;
                end
            end

            // tick item: predict its event
            if (i_tick_valid && i_tick_ready)
                expected_events.push_back(classify_tick(i_tick_data[0]));
        end
    end

endmodule

// File: sim/tb_top.sv
// Testbench top for the click classifier: drives scan ticks, limits and backpressure
module tb_top;
    import bcc_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned TICK_TARGET  = 500;
    localparam int unsigned PHASE_TICKS  = 70;
    localparam int unsigned HOLD_AT      = 120;
    localparam int unsigned HOLD_CYCLES  = 60;

    typedef enum int {
        GEST_SINGLE,
        GEST_DOUBLE,
        GEST_LONG,
        GEST_NOISE,
        GEST_GLITCH
    } t_gesture;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [LIMIT_W-1:0]   i_cfg_data = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [7:0]           m_axis_tdata;

    int unsigned fail_count;
    int unsigned pending_events;
    int unsigned checked_events;

    int unsigned cycle_count = 0;
    int unsigned ticks_sent = 0;
    int unsigned events_taken = 0;
    int unsigned setting_count = 0;
    bit          idle_on = 1'b1;
    bit          long_hold_done = 1'b0;
    int          cur_long = 100;
    int          cur_gap = 30;
    bit          tick_plan[$];

    button_click_classifier dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    bcc_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_tick_valid (s_axis_tvalid),
        .i_tick_ready (s_axis_tready),
        .i_tick_data  (s_axis_tdata),
        .i_evt_valid  (m_axis_tvalid),
        .i_evt_ready  (m_axis_tready),
        .i_evt_data   (m_axis_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending_events),
        .o_checked    (checked_events)
    );

    // clock, period 2
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // run watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d events outstanding",
                     cycle_count, pending_events);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // one tick item, after a random idle gap while idle gaps are enabled
    task automatic send_tick(input bit key);
        int gap;
        gap = idle_on ? $urandom_range(0, 5) : 0;
        repeat (gap) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, key};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        ticks_sent++;
    endtask

    task automatic flush_plan;
        while (tick_plan.size() != 0) send_tick(tick_plan.pop_front());
    endtask

    // stop offering ticks until every predicted event is out, then a short pad
    task automatic drain_events;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_events != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_limit(input logic [CFG_IDX_W-1:0] idx,
                               input logic [LIMIT_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // limits only change with the block idle; zero acts like one
    task automatic set_limits(input logic [LIMIT_W-1:0] lp, input logic [LIMIT_W-1:0] dg);
        drain_events();
        write_limit(CFG_LONG_PRESS, lp);
        write_limit(CFG_DOUBLE_GAP, dg);
        cur_long = (lp == 0) ? 1 : int'(lp);
        cur_gap  = (dg == 0) ? 1 : int'(dg);
        setting_count++;
    endtask

    task automatic push_level(input bit key, input int n);
        repeat (n) tick_plan.push_back(key);
    endtask

    // counted ticks held/released short of a limit, often right at the edge
    function automatic int pick_short(input int limit);
        if ($urandom_range(0, 3) == 0) return limit - 1;
        return $urandom_range(0, (limit - 1 < 4) ? limit - 1 : 4);
    endfunction

    function automatic t_gesture random_gesture();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3) return GEST_SINGLE;
        if (r < 6) return GEST_DOUBLE;
        if (r < 8) return GEST_LONG;
        if (r < 9) return GEST_NOISE;
        return GEST_GLITCH;
    endfunction

    // key level pattern for one user action at the current limits
    task automatic make_gesture(input t_gesture kind);
        case (kind)
            GEST_SINGLE: begin
                push_level(1'b1, 2 + pick_short(cur_long));
                push_level(1'b0, 1 + cur_gap + $urandom_range(0, 2));
            end
            GEST_DOUBLE: begin
                push_level(1'b1, 2 + pick_short(cur_long));
                push_level(1'b0, 1 + pick_short(cur_gap));
                push_level(1'b1, $urandom_range(1, 4));
                push_level(1'b0, 1 + $urandom_range(0, 2));
            end
            GEST_LONG: begin
                push_level(1'b1, 2 + cur_long + $urandom_range(0, 2));
                push_level(1'b0, 1 + $urandom_range(0, 2));
            end
            GEST_NOISE: begin
                repeat ($urandom_range(1, 8)) tick_plan.push_back(1'($urandom_range(0, 1)));
            end
            default: begin
                // press seen on one tick only
                push_level(1'b1, 1);
                push_level(1'b0, $urandom_range(1, 3));
            end
        endcase
    endtask

    // event sink with random backpressure and one long hold-off
    initial begin
        int gap;
        @(posedge i_rst_n);
        forever begin
            gap = idle_on ? $urandom_range(0, 5) : 0;
            if (!long_hold_done && events_taken == HOLD_AT) begin
                gap = HOLD_CYCLES;
                long_hold_done = 1'b1;
            end
            repeat (gap) begin
                @(negedge i_clk);
                m_axis_tready <= 1'b0;
            end
            @(negedge i_clk);
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
            events_taken++;
        end
    end

    // stimulus and verdict
    initial begin
        int phase;

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset limits: rejected glitch, then a double click
        push_level(1'b1, 1);
        push_level(1'b0, 1);
        push_level(1'b1, 3);
        push_level(1'b0, 1);
        push_level(1'b1, 2);
        push_level(1'b0, 1);
        flush_plan();

        // zero limits: glitch, long press and release, single, double
        set_limits(8'd0, 8'd0);
        push_level(1'b1, 1);
        push_level(1'b0, 1);
        push_level(1'b1, 4);
        push_level(1'b0, 1);
        push_level(1'b1, 2);
        push_level(1'b0, 2);
        push_level(1'b1, 2);
        push_level(1'b0, 1);
        push_level(1'b1, 2);
        push_level(1'b0, 1);
        flush_plan();

        // random phases, one limit setting each
        phase = 0;
        while (ticks_sent < TICK_TARGET) begin
            case (phase)
                0: set_limits(LONG_PRESS_RST, DOUBLE_GAP_RST);
                1: set_limits(8'd1, 8'd1);
                2: set_limits(8'd255, 8'd255);
                default: set_limits(($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(1, 12)),
                                    ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(1, 12)));
            endcase
            idle_on = (phase % 4) != 3;
            if (phase == 2) begin
                // largest limits: one long press, then a short press timing out to a single
                make_gesture(GEST_LONG);
                push_level(1'b1, 2);
                push_level(1'b0, 1 + cur_gap);
            end else begin
                while (tick_plan.size() < PHASE_TICKS) make_gesture(random_gesture());
            end
            flush_plan();
            phase++;
        end

        idle_on = 1'b1;
        drain_events();
        repeat (8) @(negedge i_clk);

        $display("%0d scan ticks over %0d limit settings, %0d events checked, %0d failures",
                 ticks_sent, setting_count, checked_events, fail_count);
        if (fail_count == 0 && pending_events == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
